[sv/gmcp_pkg.sv]
`timescale 1ns / 1ps
package gmcp_pkg;
   localparam int MAX_SIDE_DEF = 64;
   localparam int SIDE_W = 7;
   localparam int COST_W = 4;
   localparam int DIST_W = 16;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
endpackage

[sv/gmcp_if.sv]
`timescale 1ns / 1ps
interface gmcp_if #(parameter int W = 4);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/gmcp_ram.sv]
`timescale 1ns / 1ps
module gmcp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/grid_min_cost_path_top.sv]
`timescale 1ns / 1ps
// Grid minimum-cost path engine.
// Cells of a square grid arrive on the req channel in raster order, one item
// per cycle, each carrying a cost digit. The side length is written on the
// csr channel, which is only ready while cells are being loaded; a write
// wins over a cell offered in the same cycle and restarts the grid load.
// After the last cell the block stops accepting items and relaxes the
// distance memory with repeated sweeps until a sweep makes no change. Each
// cell is visited with a read of its own distance and one read per
// neighbour, pipelined one read per cycle; each sweep ends with a pipeline
// drain, and the number of sweeps follows the path shape (at least two). An
// initialization pass runs first, and a final read follows the last sweep.
// The result item on rsp holds the distance of the bottom-right cell; it
// stays until the receiver takes it, and loading of the next grid is held
// off meanwhile. A single-cell grid answers 0 for every item. Reset puts the
// side to 64 and clears the load count; the memories need no clearing since
// every cell read was written.
module grid_min_cost_path_top #(
   parameter int MAX_SIDE = gmcp_pkg::MAX_SIDE_DEF
) (
   input logic clock,
   input logic reset,
   gmcp_if.sink   req,
   gmcp_if.sink   csr,
   gmcp_if.source rsp
);
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(MAX_SIDE);
   localparam int SW = gmcp_pkg::SIDE_W;
   localparam int DW = gmcp_pkg::DIST_W;

   localparam logic [2:0] ST_LOAD = 3'd0, ST_INIT = 3'd1, ST_SWEEP = 3'd2,
                          ST_DRAIN = 3'd3, ST_READ = 3'd4, ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [SW-1:0] side_reg_ff, side_reg_in;
   logic [AW:0] load_ff, load_in;
   logic changed_ff, changed_in;
   logic [DW-1:0] result_ff, result_in;
   // Sweep sequencer: cell row/col and neighbour phase (0 = own, 1..4 = nb).
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic [2:0] ph_ff, ph_in;
   logic [AW-1:0] idx_ff, idx_in;
   // Pipeline stage registered behind the read address.
   logic v1_ff, v1_in;
   logic [2:0] ph1_ff, ph1_in;
   logic [AW-1:0] cell1_ff, cell1_in;
   logic nbok1_ff, nbok1_in;
   logic [DW-1:0] best_ff, best_in;
   logic dirty_ff, dirty_in;
   logic drain_ff, drain_in;

   logic [CW:0] n;
   logic [AW:0] total;
   always_comb begin
      if (side_reg_ff == '0) n = (CW+1)'(1);
      else if ((SW+1)'(side_reg_ff) > (SW+1)'(MAX_SIDE)) n = (CW+1)'(MAX_SIDE);
      else n = (CW+1)'(side_reg_ff);
      total = (AW+1)'(n) * (AW+1)'(n);
   end

   logic c_we, d_we;
   logic [AW-1:0] c_wa, d_wa, c_ra, d_ra;
   logic [gmcp_pkg::COST_W-1:0] c_rd;
   logic [DW-1:0] d_wd, d_rd;

   gmcp_ram #(.WIDTH(gmcp_pkg::COST_W), .DEPTH(CELLS)) u_cost (
      .clock(clock), .wr_en(c_we), .wr_addr(c_wa), .wr_data(req.data),
      .rd_addr(c_ra), .rd_data(c_rd));
   gmcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));

   assign req.ready = (state_ff == ST_LOAD) && !csr.valid;
   assign csr.ready = (state_ff == ST_LOAD);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.data = result_ff;

   logic [AW:0] cell_lin;
   logic [AW-1:0] nb_addr;
   logic nb_ok;
   logic [DW:0] cand;
   logic [DW-1:0] cand_sat;

   always_comb begin
      cell_lin = (AW+1)'(row_ff) * (AW+1)'(n) + (AW+1)'(col_ff);
      nb_ok = 1'b1;
      nb_addr = cell_lin[AW-1:0];
      case (ph_ff)
         3'd1: begin nb_ok = (row_ff != '0); nb_addr = cell_lin[AW-1:0] - AW'(n); end
         3'd2: begin nb_ok = ((CW+1)'(row_ff) + 1'b1 < n);
            nb_addr = cell_lin[AW-1:0] + AW'(n); end
         3'd3: begin nb_ok = (col_ff != '0); nb_addr = cell_lin[AW-1:0] - 1'b1; end
         3'd4: begin nb_ok = ((CW+1)'(col_ff) + 1'b1 < n);
            nb_addr = cell_lin[AW-1:0] + 1'b1; end
         default: ;
      endcase
      cand = {1'b0, d_rd} + (DW+1)'(c_rd);
      cand_sat = cand[DW] ? gmcp_pkg::DIST_MAX : cand[DW-1:0];
   end

   always_comb begin
      state_in = state_ff; side_reg_in = side_reg_ff; load_in = load_ff;
      changed_in = changed_ff; result_in = result_ff;
      row_in = row_ff; col_in = col_ff; ph_in = ph_ff; idx_in = idx_ff;
      v1_in = 1'b0; ph1_in = ph_ff; cell1_in = cell_lin[AW-1:0]; nbok1_in = nb_ok;
      best_in = best_ff; dirty_in = dirty_ff; drain_in = drain_ff;
      c_we = 1'b0; c_wa = load_ff[AW-1:0];
      d_we = 1'b0; d_wa = idx_ff; d_wd = gmcp_pkg::DIST_MAX;
      c_ra = cell_lin[AW-1:0]; d_ra = nb_addr;

      // Stage two: fold the neighbour candidates, write back after the last if one improved.
      if (v1_ff) begin
         if (ph1_ff == 3'd0) begin
            best_in = d_rd; dirty_in = 1'b0;
         end else if (nbok1_ff && cand_sat < best_ff) begin
            best_in = cand_sat; dirty_in = 1'b1;
         end
         if (ph1_ff == 3'd4) begin
            d_we = dirty_in; d_wa = cell1_ff; d_wd = best_in;
            if (dirty_in) changed_in = 1'b1;
         end
      end

      case (state_ff)
         ST_LOAD: begin
            if (csr.valid) begin
               side_reg_in = csr.data; load_in = '0;
            end else if (req.valid) begin
               c_we = 1'b1;
               if (load_ff + 1'b1 >= total) begin
                  load_in = '0;
                  if (n == (CW+1)'(1)) begin
                     result_in = '0; state_in = ST_OUT;
                  end else begin
                     idx_in = '0; state_in = ST_INIT;
                  end
               end else load_in = load_ff + 1'b1;
            end
         end
         ST_INIT: begin
            d_we = 1'b1; d_wa = idx_ff;
            d_wd = (idx_ff == '0) ? '0 : gmcp_pkg::DIST_MAX;
            idx_in = idx_ff + 1'b1;
            if ((AW+1)'(idx_ff) + 1'b1 >= total) begin
               row_in = '0; col_in = '0; ph_in = '0; changed_in = 1'b0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // Gauss-Seidel order: a write from the previous cell is issued in the same
            // cycle as the next cell's own read, and later reads of the written cell
            // see the new value; same-cell hazard is on own read only, which
            // follows the write.
            v1_in = 1'b1;
            if (ph_ff == 3'd4) begin
               ph_in = '0;
               if ((CW+1)'(col_ff) + 1'b1 >= n) begin
                  col_in = '0;
                  if ((CW+1)'(row_ff) + 1'b1 >= n) begin
                     row_in = '0; state_in = ST_DRAIN; drain_in = 1'b0;
                  end else row_in = row_ff + 1'b1;
               end else col_in = col_ff + 1'b1;
            end else ph_in = ph_ff + 1'b1;
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               if (changed_ff) begin
                  changed_in = 1'b0; state_in = ST_SWEEP;
               end else begin
                  d_ra = AW'(total - 1'b1); state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            result_in = d_rd; state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; side_reg_ff <= gmcp_pkg::SIDE_RESET;
         load_ff <= '0; changed_ff <= 1'b0; v1_ff <= 1'b0;
      end else begin
         state_ff <= state_in; side_reg_ff <= side_reg_in;
         load_ff <= load_in; changed_ff <= changed_in; v1_ff <= v1_in;
      end
      result_ff <= result_in; row_ff <= row_in; col_ff <= col_in;
      ph_ff <= ph_in; idx_ff <= idx_in; ph1_ff <= ph1_in;
      cell1_ff <= cell1_in; nbok1_ff <= nbok1_in; best_ff <= best_in;
      dirty_ff <= dirty_in; drain_ff <= drain_in;
   end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the grid minimum-cost path engine.
// A stimulus process writes the side register and queues grid cells; a
// clocked driver presents them on req, and a clocked monitor takes results
// from rsp and compares them against the predicted path costs.
module tb_top;
   localparam int MAX_SIDE_DEF = gmcp_pkg::MAX_SIDE_DEF;
   localparam int COST_W = gmcp_pkg::COST_W;
   localparam int SIDE_W = gmcp_pkg::SIDE_W;
   localparam int DIST_W = gmcp_pkg::DIST_W;
   localparam logic [DIST_W-1:0] DIST_MAX = gmcp_pkg::DIST_MAX;
   localparam logic [SIDE_W-1:0] SIDE_RESET = gmcp_pkg::SIDE_RESET;

   localparam int MAX_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gmcp_if #(.W(COST_W)) req_if ();
   gmcp_if #(.W(SIDE_W)) csr_if ();
   gmcp_if #(.W(DIST_W)) rsp_if ();

   grid_min_cost_path_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .csr   (csr_if),
      .rsp   (rsp_if)
   );

   always #10 clock = ~clock;

   // Cells waiting to be driven, and path costs waiting to be seen.
   logic [COST_W-1:0] cell_q[$];
   logic [DIST_W-1:0] path_cost_q[$];

   // Cost digits of the grid being built, in raster order.
   logic [COST_W-1:0] grid_cost[MAX_CELLS];

   int mismatches = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   bit quiet = 1'b0;     // When set, neither side idles.
   int side_now;         // Effective side length held by the predictor.
   int cells_sent = 0;

   // Effective side for a raw register value: zero acts as one, and
   // anything above the maximum is clipped to the maximum.
   function automatic int side_of(input logic [SIDE_W-1:0] raw);
      int s;
      s = raw;
      if (s == 0) s = 1;
      if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
      return s;
   endfunction

   // Least path cost over the grid held in grid_cost, found by relaxation
   // sweeps in raster order until a sweep changes nothing.
   function automatic logic [DIST_W-1:0] min_path_cost(input int n);
      int dist_arr[MAX_CELLS];
      int cand;
      int nb;
      bit changed;
      for (int i = 0; i < n * n; i++) dist_arr[i] = DIST_MAX;
      dist_arr[0] = 0;
      do begin
         changed = 1'b0;
         for (int i = 0; i < n * n; i++) begin
            for (int d = 0; d < 4; d++) begin
               nb = -1;
               if (d == 0 && i / n > 0) nb = i - n;
               if (d == 1 && i / n + 1 < n) nb = i + n;
               if (d == 2 && i % n > 0) nb = i - 1;
               if (d == 3 && i % n + 1 < n) nb = i + 1;
               if (nb >= 0) begin
                  cand = dist_arr[nb] + grid_cost[i];
                  if (cand > DIST_MAX) cand = DIST_MAX;
                  if (cand < dist_arr[i]) begin
                     dist_arr[i] = cand;
                     changed = 1'b1;
                  end
               end
            end
         end
      end while (changed);
      return DIST_W'(dist_arr[n * n - 1]);
   endfunction

   // Waits until every cell is taken and every result has arrived, then
   // lets the block settle before anything else happens.
   task automatic wait_idle();
      while (cell_q.size() != 0 || req_if.valid || path_cost_q.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Writes the side register while the block is idle. The write also
   // restarts the grid load, so the predictor starts from an empty grid.
   task automatic write_side(input logic [SIDE_W-1:0] raw);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.data <= raw;
      forever begin
         @(posedge clock);
         if (csr_if.valid && csr_if.ready) break;
      end
      csr_if.valid <= 1'b0;
      side_now = side_of(raw);
   endtask

   // Queues one full grid. A fill of 16 or more asks for random costs,
   // otherwise every cell gets that fill value.
   task automatic send_grid(input int fill);
      for (int i = 0; i < side_now * side_now; i++) begin
         grid_cost[i] = (fill > 15) ? COST_W'($urandom_range(0, 15)) : COST_W'(fill);
         cell_q.push_back(grid_cost[i]);
      end
      path_cost_q.push_back(min_path_cost(side_now));
      cells_sent += side_now * side_now;
   endtask

   // Queues a grid that is cut short; the next register write drops it.
   task automatic send_partial(input int count);
      for (int i = 0; i < count; i++)
         cell_q.push_back(COST_W'($urandom_range(0, 15)));
      cells_sent += count;
   endtask

   // Driver: presents queued cells, holding each until it is accepted, and
   // idles in random bursts between items.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
         req_gap <= 0;
      end else begin
         if (req_if.valid && req_if.ready) void'(cell_q.pop_front());
         if (req_if.valid && !req_if.ready) begin
            // Item not taken yet, so it stays on the bus.
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_if.valid <= 1'b0;
         end else if (cell_q.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.data <= cell_q[0];
            if (!quiet && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 8);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: takes result items with random stalls and checks each one
   // against the oldest predicted path cost.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (path_cost_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item: path_cost=%0d", rsp_if.data);
            end else begin
               if (rsp_if.data !== path_cost_q[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("path_cost mismatch: expected %0d, actual %0d",
                              path_cost_q[0], rsp_if.data);
               end
               void'(path_cost_q.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) rsp_gap <= $urandom_range(1, 8);
         end
      end
   end

   // Main stimulus: directed cases first, then random grids.
   initial begin
      int n;
      int reps;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      side_now = side_of(SIDE_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A load at the full size after reset is cut short by the first write.
      send_partial(5);
      // A single-cell grid answers zero for every item, whatever its cost.
      write_side(7'd1);
      send_grid(0);
      send_grid(15);
      // A side of zero acts like a side of one.
      write_side(7'd0);
      send_grid(16);
      // Smallest real grid with the largest costs.
      write_side(7'd2);
      send_grid(15);
      // A cut-short load, then a rewrite of the same side restarts it.
      write_side(7'd3);
      send_partial(4);
      write_side(7'd3);
      send_grid(16);
      // A side above the maximum is clipped; the load is dropped again.
      write_side(7'd127);
      send_partial(20);

      // Random grids, mostly small, with the odd broken load.
      while (cells_sent < 750) begin
         if (cells_sent > 620) quiet = 1'b1;
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
         if (n == 1 && $urandom_range(0, 1) == 0) n = 0;
         write_side(SIDE_W'(n));
         reps = $urandom_range(1, 3);
         for (int g = 0; g < reps; g++) send_grid(16);
         if (side_now > 1 && $urandom_range(0, 6) == 0)
            send_partial($urandom_range(1, side_now * side_now - 1));
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #200ms;
      $display("FAILURE");
      $finish;
   end
endmodule

[filelist.f]
sv/gmcp_pkg.sv
sv/gmcp_if.sv
sv/gmcp_ram.sv
sv/grid_min_cost_path_top.sv
tb/tb_top.sv
